/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* hdl/u8250_pkg.sv */
// Package: item types, opcodes, register offsets and constants of the UART register model.
package u8250_pkg;

    localparam int RX_DEPTH_DEF = 16;

    // item opcodes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RX    = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // register offsets
    localparam logic [3:0] REG_RBR = 4'd0;  // THR on write, DLL with DLAB
    localparam logic [3:0] REG_IER = 4'd1;  // DLM with DLAB
    localparam logic [3:0] REG_IIR = 4'd2;  // FCR on write
    localparam logic [3:0] REG_LCR = 4'd3;
    localparam logic [3:0] REG_MCR = 4'd4;
    localparam logic [3:0] REG_LSR = 4'd5;
    localparam logic [3:0] REG_MSR = 4'd6;
    localparam logic [3:0] REG_SCR = 4'd7;

    localparam int          DLAB_BIT  = 7;
    localparam logic [7:0]  LSR_EMPTY = 8'h60;
    localparam logic [7:0]  MSR_FIXED = 8'hB0;
    localparam int          PEND_RX   = 0;
    localparam int          PEND_TX   = 1;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] reg_address;
        logic [7:0] data_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq;
        logic       status;
    } t_out_item;

endpackage

/* hdl/u8250_stream_if.sv */
// Interface: valid/ready stream channel carrying one payload item per transfer.
interface u8250_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/uart_8250_register_model.sv */
// Top level: 8250-style UART register model with receive FIFO held in RAM.
//
//  channel    | dir | payload                                   | transfer when
//  -----------+-----+-------------------------------------------+---------------------
//  i_item     | in  | opcode, reg_address, data_in              | valid && ready
//  o_result   | out | read_data, tx_valid, tx_byte, irq, status | valid && ready
//
// One item per cycle sustained while o_result takes each result; each item gives exactly one result.
// Registers and FIFO pointers update at the accepting edge, and the result sits in the
// output register the cycle after.
// An RBR pop reads the FIFO RAM at the accepting edge; the RAM's registered read
// data drives read_data directly while that result waits in the output register.
// i_item.ready = output register empty or being taken, so a stall holds one result
// and backs up the input. Synchronous reset clears all control state; no clear pass.
`include "assert_macros.svh"

module uart_8250_register_model #(
    parameter int RX_DEPTH = u8250_pkg::RX_DEPTH_DEF,
    localparam int PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1,
    localparam int CW = $clog2(RX_DEPTH + 1)
) (
    input  logic i_clk,
    input  logic i_rst_n,
    u8250_stream_if.sink   i_item,
    u8250_stream_if.source o_result
);
    localparam logic [PW-1:0] LAST_SLOT = PW'(RX_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(RX_DEPTH);

    // architectural registers
    logic [7:0]    r_lcr, n_lcr;
    logic [7:0]    r_ier, n_ier;
    logic [7:0]    r_mcr, n_mcr;
    logic [7:0]    r_dll, n_dll;
    logic [7:0]    r_dlm, n_dlm;
    logic [1:0]    r_pend, n_pend;
    logic          r_cur_int, n_cur_int;
    logic          r_irq_level, n_irq_level;
    logic [PW-1:0] r_rx_head, n_rx_head;
    logic [PW-1:0] r_rx_tail, n_rx_tail;
    logic [CW-1:0] r_rx_count, n_rx_count;

    // output register
    logic                  r_out_valid;
    u8250_pkg::t_out_item  r_out, n_out;
    logic                  r_use_ram, n_use_ram;

    // FIFO RAM port
    logic       ram_we, ram_re;
    logic [7:0] ram_rdata;

    logic                 accept;
    logic                 dlab;
    u8250_pkg::t_in_item  item;
    logic [1:0]           tick_p;

    assign item   = i_item.data;
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept = i_item.valid && i_item.ready;
    assign dlab   = r_lcr[u8250_pkg::DLAB_BIT];
    assign tick_p = {r_pend[u8250_pkg::PEND_TX], (r_rx_count != '0)} & r_ier[1:0];

    always_comb begin
        n_lcr       = r_lcr;
        n_ier       = r_ier;
        n_mcr       = r_mcr;
        n_dll       = r_dll;
        n_dlm       = r_dlm;
        n_pend      = r_pend;
        n_cur_int   = r_cur_int;
        n_irq_level = r_irq_level;
        n_rx_head   = r_rx_head;
        n_rx_tail   = r_rx_tail;
        n_rx_count  = r_rx_count;
        n_out       = '0;
        n_use_ram   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        case (item.opcode)
            u8250_pkg::OP_READ: begin
                case (item.reg_address)
                    u8250_pkg::REG_RBR: begin
                        if (dlab) begin
                            n_out.read_data = r_dll;
                        end else if (r_rx_count != '0) begin
                            // pop: data comes from the RAM read register
                            ram_re     = 1'b1;
                            n_use_ram  = 1'b1;
                            n_rx_head  = (r_rx_head == LAST_SLOT) ? '0 : r_rx_head + PW'(1);
                            n_rx_count = r_rx_count - CW'(1);
                        end
                    end
                    u8250_pkg::REG_IER: n_out.read_data = dlab ? r_dlm : r_ier;
                    u8250_pkg::REG_IIR: begin
                        n_out.read_data = {6'd0, r_cur_int, (r_pend == 2'b00)};
                        if (r_cur_int) begin
                            n_pend[u8250_pkg::PEND_TX] = 1'b0;
                        end
                    end
                    u8250_pkg::REG_LCR: n_out.read_data = r_lcr;
                    u8250_pkg::REG_MCR: n_out.read_data = r_mcr;
                    u8250_pkg::REG_LSR: begin
                        n_out.read_data = u8250_pkg::LSR_EMPTY
                                          | {7'd0, (!dlab && r_rx_count != '0)};
                    end
                    u8250_pkg::REG_MSR: n_out.read_data = u8250_pkg::MSR_FIXED;
                    u8250_pkg::REG_SCR: n_out.read_data = 8'd0;
                    default:            n_out.status = 1'b1;
                endcase
            end
            u8250_pkg::OP_WRITE: begin
                case (item.reg_address)
                    u8250_pkg::REG_RBR: begin
                        if (dlab) begin
                            n_dll = item.data_in;
                        end else begin
                            n_out.tx_valid = 1'b1;
                            n_out.tx_byte  = item.data_in;
                            n_pend[u8250_pkg::PEND_TX] = 1'b1;
                        end
                    end
                    u8250_pkg::REG_IER: begin
                        if (dlab) begin
                            n_dlm = item.data_in;
                        end else begin
                            n_ier = item.data_in;
                        end
                    end
                    u8250_pkg::REG_IIR: ;  // FCR ignored
                    u8250_pkg::REG_LCR: n_lcr = item.data_in;
                    u8250_pkg::REG_MCR: n_mcr = item.data_in;
                    u8250_pkg::REG_SCR: ;
                    default:            n_out.status = 1'b1;
                endcase
            end
            u8250_pkg::OP_RX: begin
                // zero bytes and bytes arriving on a full FIFO are dropped
                if (item.data_in != 8'd0 && r_rx_count < FULL_CNT) begin
                    ram_we     = 1'b1;
                    n_rx_tail  = (r_rx_tail == LAST_SLOT) ? '0 : r_rx_tail + PW'(1);
                    n_rx_count = r_rx_count + CW'(1);
                end
            end
            u8250_pkg::OP_TICK: begin
                n_pend = tick_p;
                if (tick_p != 2'b00) begin
                    n_cur_int   = tick_p[u8250_pkg::PEND_TX];
                    n_irq_level = 1'b1;
                end else begin
                    n_irq_level = 1'b0;
                end
            end
            default: ;
        endcase

        n_out.irq = n_irq_level;

        // no state change unless the item transfers
        if (!accept) begin
            ram_we = 1'b0;
            ram_re = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcr       <= '0;
            r_ier       <= '0;
            r_mcr       <= '0;
            r_dll       <= '0;
            r_dlm       <= '0;
            r_pend      <= '0;
            r_cur_int   <= 1'b0;
            r_irq_level <= 1'b0;
            r_rx_head   <= '0;
            r_rx_tail   <= '0;
            r_rx_count  <= '0;
            r_out_valid <= 1'b0;
            r_use_ram   <= 1'b0;
        end else begin
            if (accept) begin
                r_lcr       <= n_lcr;
                r_ier       <= n_ier;
                r_mcr       <= n_mcr;
                r_dll       <= n_dll;
                r_dlm       <= n_dlm;
                r_pend      <= n_pend;
                r_cur_int   <= n_cur_int;
                r_irq_level <= n_irq_level;
                r_rx_head   <= n_rx_head;
                r_rx_tail   <= n_rx_tail;
                r_rx_count  <= n_rx_count;
                r_use_ram   <= n_use_ram;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    u8250_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_rx_tail),
        .i_wdata (item.data_in),
        .i_re    (ram_re),
        .i_raddr (r_rx_head),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_result.data = r_out;
        if (r_use_ram) begin
            o_result.data.read_data = ram_rdata;
        end
    end
    assign o_result.valid = r_out_valid;

    // FIFO occupancy never exceeds its depth
    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_rx_count > FULL_CNT)
    // a pop is only issued on a non-empty FIFO and drops the count by one
    `ASSERT_HOLDS(a_pop_nonempty, i_clk, i_rst_n, ram_re |-> r_rx_count != '0)
    `ASSERT_HOLDS(a_pop_count, i_clk, i_rst_n,
                  ram_re |=> r_rx_count == $past(r_rx_count) - CW'(1))
    // push and pop never share a cycle
    `ASSERT_NEVER(a_push_pop, i_clk, i_rst_n, ram_we && ram_re)
    // the held result always reports the current irq level
    `ASSERT_HOLDS(a_irq_match, i_clk, i_rst_n,
                  r_out_valid |-> o_result.data.irq == r_irq_level)
endmodule

/* hdl/u8250_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module u8250_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
